// ===== rtl/cswl_pkg.sv =====
// cswl_pkg: sizes, types and sequencer states of the cyclic step-waveform lookup
// used by cyclic_step_waveform_lookup; no dependencies
package cswl_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int DURATION_BITS = 16;
   localparam int TIME_BITS     = 32;
   localparam int LEVEL_BITS    = 32;

   localparam int IDX_W    = 4;   // entry_index field
   localparam int SEG_W    = 4;   // segment field
   localparam int PH_W     = 17;  // phase register, Q0.16 plus the full-period bit
   localparam int PH_FRAC  = 16;
   localparam int PH_FULL  = 65536;
   // room for the durations of all slots and some slack
   localparam int SUM_BITS = DURATION_BITS + $clog2(MAX_ENTRIES + 1);
   localparam int ST_DEPTH = MAX_ENTRIES + 1;
   localparam int ST_AW    = $clog2(ST_DEPTH);
   localparam int LV_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int WK_W     = ST_AW + 1;
   localparam int DIV_CW   = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;

   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [SUM_BITS:0]        sum1_type;
   typedef logic [SUM_BITS+PH_W-1:0] prod_type;
   typedef logic [PH_W-1:0]          phase_type;
   typedef logic [ST_AW-1:0]         st_addr_type;
   typedef logic [LV_AW-1:0]         lv_addr_type;
   typedef logic [WK_W-1:0]          walk_type;
   typedef logic [DIV_CW-1:0]        div_cnt_type;
   typedef logic [SEG_W-1:0]         seg_type;
   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [DURATION_BITS-1:0] dur_type;
   typedef logic [LEVEL_BITS-1:0]    level_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD2,
      S_PER,
      S_MUL,
      S_DIV,
      S_FIX,
      S_WALK,
      S_LVL,
      S_RESP
   } state_type;

endpackage

// ===== rtl/cswl_ram.sv =====
// cswl_ram: generic single-write, single-read ram with registered read data
// no dependencies
module cswl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cyclic_step_waveform_lookup.sv =====
// cyclic_step_waveform_lookup: sequencer around the start-time and level rams
// depends on cswl_pkg and cswl_ram
//
// A load beat writes the start-time ram in S_IDLE and again in S_LOAD2 (the two
// start-time writes share one ram port). A query steps through S_PER, S_MUL, a
// bit-serial remainder in S_DIV of one step per cycle, S_FIX, then a walk over the
// start-time ram in S_WALK at one entry per cycle, S_LVL and S_RESP. When no
// segment holds the time the walk covers the whole list. An empty table answers
// from S_IDLE straight into S_RESP and a zero period from S_MUL. New beats are
// taken only between items, but a finished result waits in its output register
// while the next item is taken.
module cyclic_step_waveform_lookup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [cswl_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [cswl_pkg::DURATION_BITS-1:0] req_duration,
   input  logic signed [cswl_pkg::LEVEL_BITS-1:0] req_level_in,
   input  logic                            req_last_entry,
   input  logic [cswl_pkg::TIME_BITS-1:0]  req_time_now,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cswl_pkg::LEVEL_BITS-1:0] rsp_level_out,
   output logic [cswl_pkg::SEG_W-1:0]      rsp_segment,
   output logic                            rsp_no_table,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cswl_pkg::PH_W-1:0]       csr_phase_delay
);

   cswl_pkg::state_type   state_ff, state_in;
   cswl_pkg::st_addr_type cnt_ff, cnt_in;
   cswl_pkg::sum_type     sum_ff, sum_in;
   cswl_pkg::phase_type   phase_ff;
   cswl_pkg::st_addr_type nxt_addr_ff, nxt_addr_in;
   cswl_pkg::time_type    time_ff, time_in;
   cswl_pkg::time_type    tsh_ff, tsh_in;
   cswl_pkg::sum_type     period_ff, period_in;
   cswl_pkg::prod_type    prod_ff, prod_in;
   cswl_pkg::sum_type     offset_ff, offset_in;
   cswl_pkg::sum_type     rem_ff, rem_in;
   cswl_pkg::div_cnt_type div_cnt_ff, div_cnt_in;
   cswl_pkg::walk_type    walk_ff, walk_in;
   logic                  dv_ff, dv_in;
   cswl_pkg::st_addr_type dk_ff, dk_in;
   cswl_pkg::sum_type     prev_ff, prev_in;
   cswl_pkg::lv_addr_type seg_ff, seg_in;
   cswl_pkg::level_type   lvl_ff, lvl_in;
   logic                  nt_ff, nt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cswl_pkg::level_type   rsp_level_ff, rsp_level_in;
   cswl_pkg::seg_type     rsp_seg_ff, rsp_seg_in;
   logic                  rsp_nt_ff, rsp_nt_in;

   logic                  st_we, st_re;
   cswl_pkg::st_addr_type st_waddr, st_raddr;
   cswl_pkg::sum_type     st_wdata, st_rdata;
   logic                  lv_we, lv_re;
   cswl_pkg::lv_addr_type lv_waddr, lv_raddr;
   cswl_pkg::level_type   lv_wdata, lv_rdata;

   cswl_pkg::phase_type   ph_sat;
   cswl_pkg::sum_type     base_sum;
   cswl_pkg::sum1_type    trial;
   cswl_pkg::sum1_type    wrap;
   logic                  hit;

   cswl_ram #(.WIDTH(cswl_pkg::SUM_BITS), .DEPTH(cswl_pkg::ST_DEPTH)) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   cswl_ram #(.WIDTH(cswl_pkg::LEVEL_BITS), .DEPTH(cswl_pkg::MAX_ENTRIES)) u_level_ram (
      .clock   (clock),
      .wr_en   (lv_we),
      .wr_addr (lv_waddr),
      .wr_data (lv_wdata),
      .rd_en   (lv_re),
      .rd_addr (lv_raddr),
      .rd_data (lv_rdata)
   );

   assign req_ready     = (state_ff == cswl_pkg::S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level_out = rsp_level_ff;
   assign rsp_segment   = rsp_seg_ff;
   assign rsp_no_table  = rsp_nt_ff;

   assign ph_sat   = (phase_ff > cswl_pkg::phase_type'(cswl_pkg::PH_FULL)) ?
                     cswl_pkg::phase_type'(cswl_pkg::PH_FULL) : phase_ff;
   assign base_sum = (req_entry_index == '0) ? '0 : sum_ff;
   assign trial    = {rem_ff, tsh_ff[cswl_pkg::TIME_BITS-1]};
   assign wrap     = cswl_pkg::sum1_type'(rem_ff) + cswl_pkg::sum1_type'(offset_ff);
   assign hit      = dv_ff && (dk_ff != '0) && (prev_ff <= rem_ff) && (rem_ff < st_rdata);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      nxt_addr_in  = nxt_addr_ff;
      time_in      = time_ff;
      tsh_in       = tsh_ff;
      period_in    = period_ff;
      prod_in      = prod_ff;
      offset_in    = offset_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      walk_in      = walk_ff;
      dv_in        = 1'b0;
      dk_in        = dk_ff;
      prev_in      = prev_ff;
      seg_in       = seg_ff;
      lvl_in       = lvl_ff;
      nt_in        = nt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_nt_in    = rsp_nt_ff;
      st_we        = 1'b0;
      st_waddr     = '0;
      st_wdata     = '0;
      st_re        = 1'b0;
      st_raddr     = '0;
      lv_we        = 1'b0;
      lv_waddr     = '0;
      lv_wdata     = '0;
      lv_re        = 1'b0;
      lv_raddr     = '0;

      case (state_ff)
         cswl_pkg::S_IDLE: begin
            if (req_valid) begin
               if (!req_func) begin
                  if (int'(req_entry_index) < cswl_pkg::MAX_ENTRIES) begin
                     st_we       = 1'b1;
                     st_waddr    = cswl_pkg::st_addr_type'(req_entry_index);
                     st_wdata    = base_sum;
                     lv_we       = 1'b1;
                     lv_waddr    = cswl_pkg::lv_addr_type'(req_entry_index);
                     lv_wdata    = cswl_pkg::level_type'(req_level_in);
                     sum_in      = base_sum + cswl_pkg::sum_type'(req_duration);
                     nxt_addr_in = cswl_pkg::st_addr_type'(req_entry_index) + 1'b1;
                     if (req_entry_index == '0) begin
                        cnt_in = '0;
                     end
                     if (req_last_entry) begin
                        cnt_in = cswl_pkg::st_addr_type'(req_entry_index) + 1'b1;
                     end
                     state_in = cswl_pkg::S_LOAD2;
                  end
               end else begin
                  time_in = req_time_now;
                  if (cnt_ff == '0) begin
                     nt_in    = 1'b1;
                     seg_in   = '0;
                     lvl_in   = '0;
                     state_in = cswl_pkg::S_RESP;
                  end else begin
                     st_re    = 1'b1;
                     st_raddr = cnt_ff;
                     state_in = cswl_pkg::S_PER;
                  end
               end
            end
         end
         cswl_pkg::S_LOAD2: begin
            st_we    = 1'b1;
            st_waddr = nxt_addr_ff;
            st_wdata = sum_ff;
            state_in = cswl_pkg::S_IDLE;
         end
         cswl_pkg::S_PER: begin
            period_in = st_rdata;
            state_in  = cswl_pkg::S_MUL;
         end
         cswl_pkg::S_MUL: begin
            if (period_ff == '0) begin
               nt_in    = 1'b1;
               seg_in   = '0;
               lvl_in   = '0;
               state_in = cswl_pkg::S_RESP;
            end else begin
               prod_in    = cswl_pkg::prod_type'(period_ff) * cswl_pkg::prod_type'(ph_sat);
               rem_in     = '0;
               tsh_in     = time_ff;
               div_cnt_in = cswl_pkg::div_cnt_type'(cswl_pkg::TIME_BITS - 1);
               state_in   = cswl_pkg::S_DIV;
            end
         end
         cswl_pkg::S_DIV: begin
            // restoring remainder, one time bit a cycle
            if (trial >= {1'b0, period_ff}) begin
               rem_in = cswl_pkg::sum_type'(trial - {1'b0, period_ff});
            end else begin
               rem_in = cswl_pkg::sum_type'(trial);
            end
            tsh_in    = tsh_ff << 1;
            offset_in = period_ff - cswl_pkg::sum_type'(prod_ff >> cswl_pkg::PH_FRAC);
            if (div_cnt_ff == '0) begin
               state_in = cswl_pkg::S_FIX;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         cswl_pkg::S_FIX: begin
            // offset is at most one period, so one subtract wraps it
            if (wrap >= {1'b0, period_ff}) begin
               rem_in = cswl_pkg::sum_type'(wrap - {1'b0, period_ff});
            end else begin
               rem_in = cswl_pkg::sum_type'(wrap);
            end
            walk_in  = '0;
            state_in = cswl_pkg::S_WALK;
         end
         cswl_pkg::S_WALK: begin
            if (walk_ff <= cswl_pkg::walk_type'(cnt_ff)) begin
               st_re    = 1'b1;
               st_raddr = cswl_pkg::st_addr_type'(walk_ff);
               dv_in    = 1'b1;
               dk_in    = cswl_pkg::st_addr_type'(walk_ff);
               walk_in  = walk_ff + 1'b1;
            end
            if (dv_ff) begin
               prev_in = st_rdata;
               if (hit || (dk_ff == cnt_ff)) begin
                  // no hit selects entry 0
                  seg_in   = hit ? cswl_pkg::lv_addr_type'(dk_ff - 1'b1) : '0;
                  lv_re    = 1'b1;
                  lv_raddr = hit ? cswl_pkg::lv_addr_type'(dk_ff - 1'b1) : '0;
                  nt_in    = 1'b0;
                  dv_in    = 1'b0;
                  state_in = cswl_pkg::S_LVL;
               end
            end
         end
         cswl_pkg::S_LVL: begin
            lvl_in   = lv_rdata;
            state_in = cswl_pkg::S_RESP;
         end
         cswl_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = lvl_ff;
               rsp_seg_in   = cswl_pkg::seg_type'(seg_ff);
               rsp_nt_in    = nt_ff;
               state_in     = cswl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cswl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cswl_pkg::S_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         phase_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            phase_ff <= csr_phase_delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      nxt_addr_ff  <= nxt_addr_in;
      time_ff      <= time_in;
      tsh_ff       <= tsh_in;
      period_ff    <= period_in;
      prod_ff      <= prod_in;
      offset_ff    <= offset_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      walk_ff      <= walk_in;
      dk_ff        <= dk_in;
      prev_ff      <= prev_in;
      seg_ff       <= seg_in;
      lvl_ff       <= lvl_in;
      nt_ff        <= nt_in;
      rsp_level_ff <= rsp_level_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_nt_ff    <= rsp_nt_in;
   end

   a_nt_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nt_ff) |-> (rsp_level_ff == '0 && rsp_seg_ff == '0))
      else $error("empty-table beat carries a level or segment");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cswl_pkg::S_DIV) |-> (rem_ff < period_ff))
      else $error("partial remainder reached the period");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cswl_pkg::S_WALK) |-> (rem_ff < period_ff))
      else $error("phased time not reduced below the period");

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= cswl_pkg::MAX_ENTRIES)
      else $error("entry count beyond table size");

endmodule
